// ===== rtl/core/modbus_rtu_level_responder_defines.svh =====
// ----------------------------------------------------------------------------
// Modbus RTU level responder - assertion macros
// Shared concurrent assertion forms for the responder RTL.
// ----------------------------------------------------------------------------
`ifndef MODBUS_RTU_LEVEL_RESPONDER_DEFINES_SVH
`define MODBUS_RTU_LEVEL_RESPONDER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define MRTU_ASSERT_IMPLY(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("mrtu: same-cycle check failed");

// next-cycle implication, checked out of reset
`define MRTU_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("mrtu: next-cycle check failed");

`endif

// ===== rtl/core/mrtu_pkg.sv =====
// ----------------------------------------------------------------------------
// Modbus RTU level responder package
// Constants, CRC-16/MODBUS byte step and the reply load struct.
// ----------------------------------------------------------------------------
package mrtu_pkg;

    localparam int unsigned MAX_FRAME_DEFAULT = 255;

    localparam logic [15:0] CRC_INIT         = 16'hFFFF;
    localparam logic [15:0] CRC_POLY         = 16'hA001;
    localparam logic [7:0]  FUNC_READ        = 8'h03;
    localparam logic [7:0]  BYTE_COUNT_FIELD = 8'h02;
    localparam logic [7:0]  SLAVE_ADDR_RESET = 8'h01;
    localparam logic [8:0]  COUNT_SAT        = 9'd511;

    // reply byte positions
    localparam logic [2:0] POS_ADDR   = 3'd0;
    localparam logic [2:0] POS_FUNC   = 3'd1;
    localparam logic [2:0] POS_COUNT  = 3'd2;
    localparam logic [2:0] POS_VAL_HI = 3'd3;
    localparam logic [2:0] POS_VAL_LO = 3'd4;
    localparam logic [2:0] POS_CRC_LO = 3'd5;
    localparam logic [2:0] POS_CRC_HI = 3'd6;

    typedef struct packed {
        logic        valid;
        logic [7:0]  addr;
        logic [15:0] value;
    } reply_load_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/mrtu_frame_check.sv =====
// ----------------------------------------------------------------------------
// Modbus RTU frame checker
// Input register, running CRC, frame capture and end-of-frame validation.
// ----------------------------------------------------------------------------
module mrtu_frame_check #(
    parameter int unsigned MAX_FRAME = mrtu_pkg::MAX_FRAME_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  in_cmd,
    input  logic [7:0]            in_byte,
    input  logic                  in_end,
    input  logic [15:0]           in_level,
    input  logic [7:0]            slave_address,
    input  logic                  load_ok,
    output mrtu_pkg::reply_load_t load
);

    localparam logic [8:0] MaxFrame = 9'(MAX_FRAME);

    logic        in_valid_reg;
    logic        cmd_reg;
    logic [7:0]  byte_reg;
    logic        end_reg;
    logic [15:0] level_in_reg;

    logic [15:0] level_reg;
    logic [15:0] crc_reg,   crc_next;
    logic [8:0]  count_reg, count_next;
    logic [7:0]  tail0_reg, tail0_next;
    logic [7:0]  tail1_reg, tail1_next;
    logic [7:0]  addr_reg,  addr_next;
    logic [7:0]  func_reg,  func_next;
    logic [7:0]  pay0_reg,  pay0_next;
    logic [7:0]  pay1_reg,  pay1_next;

    logic        advance;
    logic        frame_byte;
    logic [15:0] crc_step;
    logic [7:0]  pay1_fin;
    logic        good;
    logic [15:0] value;

    assign frame_byte = in_valid_reg && !cmd_reg;
    // a frame end may start a reply, so hold it until the reply buffer can take one
    assign advance  = in_valid_reg && (cmd_reg || !end_reg || load_ok);
    assign in_ready = !in_valid_reg || advance;

    always_comb
    begin
        crc_step = (count_reg >= 9'd2) ? mrtu_pkg::crc_byte(crc_reg, tail0_reg) : crc_reg;
        pay1_fin = (count_reg == 9'd4) ? byte_reg : pay1_reg;
        good = end_reg && (count_reg >= 9'd3) && (count_reg < MaxFrame)
            && (tail1_reg == crc_step[7:0]) && (byte_reg == crc_step[15:8])
            && (addr_reg == slave_address) && (func_reg == mrtu_pkg::FUNC_READ);
        // odd length means the last index is even
        if (count_reg[0])
            value = level_reg;
        else
            value = {pay0_reg, pay1_fin} + level_reg;

        crc_next   = crc_step;
        count_next = (count_reg < mrtu_pkg::COUNT_SAT) ? count_reg + 9'd1 : count_reg;
        tail0_next = tail1_reg;
        tail1_next = byte_reg;
        addr_next  = (count_reg == 9'd0) ? byte_reg : addr_reg;
        func_next  = (count_reg == 9'd1) ? byte_reg : func_reg;
        pay0_next  = (count_reg == 9'd3) ? byte_reg : pay0_reg;
        pay1_next  = pay1_fin;
        if (end_reg)
        begin
            crc_next   = mrtu_pkg::CRC_INIT;
            count_next = '0;
            tail0_next = '0;
            tail1_next = '0;
            addr_next  = '0;
            func_next  = '0;
            pay0_next  = '0;
            pay1_next  = '0;
        end
    end

    assign load.valid = advance && frame_byte && good;
    assign load.addr  = slave_address;
    assign load.value = value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            level_reg    <= '0;
            crc_reg      <= mrtu_pkg::CRC_INIT;
            count_reg    <= '0;
            tail0_reg    <= '0;
            tail1_reg    <= '0;
            addr_reg     <= '0;
            func_reg     <= '0;
            pay0_reg     <= '0;
            pay1_reg     <= '0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance && cmd_reg)
                level_reg <= level_in_reg;
            if (advance && frame_byte)
            begin
                crc_reg   <= crc_next;
                count_reg <= count_next;
                tail0_reg <= tail0_next;
                tail1_reg <= tail1_next;
                addr_reg  <= addr_next;
                func_reg  <= func_next;
                pay0_reg  <= pay0_next;
                pay1_reg  <= pay1_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg      <= in_cmd;
            byte_reg     <= in_byte;
            end_reg      <= in_end;
            level_in_reg <= in_level;
        end
    end

endmodule

// ===== rtl/core/mrtu_reply_tx.sv =====
// ----------------------------------------------------------------------------
// Modbus RTU reply sender
// Holds one reply and sends its seven bytes, building the reply CRC on the way.
// ----------------------------------------------------------------------------
module mrtu_reply_tx (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mrtu_pkg::reply_load_t load,
    output logic                  load_ok,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            out_byte,
    output logic                  out_last
);

    logic        busy_reg;
    logic [2:0]  pos_reg;
    logic [7:0]  addr_reg;
    logic [15:0] value_reg;
    logic [15:0] crc_reg;
    logic        take;

    assign out_valid = busy_reg;
    assign out_last  = (pos_reg == mrtu_pkg::POS_CRC_HI);
    assign take      = busy_reg && out_ready;
    assign load_ok   = !busy_reg || (take && out_last);

    always_comb
    begin
        case (pos_reg)
            mrtu_pkg::POS_ADDR:   out_byte = addr_reg;
            mrtu_pkg::POS_FUNC:   out_byte = mrtu_pkg::FUNC_READ;
            mrtu_pkg::POS_COUNT:  out_byte = mrtu_pkg::BYTE_COUNT_FIELD;
            mrtu_pkg::POS_VAL_HI: out_byte = value_reg[15:8];
            mrtu_pkg::POS_VAL_LO: out_byte = value_reg[7:0];
            mrtu_pkg::POS_CRC_LO: out_byte = crc_reg[7:0];
            mrtu_pkg::POS_CRC_HI: out_byte = crc_reg[15:8];
            default:              out_byte = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pos_reg  <= mrtu_pkg::POS_ADDR;
        end
        else if (load.valid)
        begin
            busy_reg <= 1'b1;
            pos_reg  <= mrtu_pkg::POS_ADDR;
        end
        else if (take)
        begin
            if (out_last)
                busy_reg <= 1'b0;
            else
                pos_reg <= pos_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load.valid)
        begin
            addr_reg  <= load.addr;
            value_reg <= load.value;
            crc_reg   <= mrtu_pkg::CRC_INIT;
        end
        else if (take && (pos_reg < mrtu_pkg::POS_CRC_LO))
        begin
            // fold each header and value byte into the reply CRC as it leaves
            crc_reg <= mrtu_pkg::crc_byte(crc_reg, out_byte);
        end
    end

endmodule

// ===== rtl/core/modbus_rtu_level_responder.sv =====
// ----------------------------------------------------------------------------
// Modbus RTU level responder
// Checks read frames and answers with the stored water level, plus payload if odd.
// ----------------------------------------------------------------------------
//  channel   direction  tdata                          tuser  tlast
//  s_axis    in         [7:0] rx_byte, [23:8] level    cmd    frame_end
//  m_axis    out        [7:0] tx_byte                  -      tx_last
//  cfg       in         cfg_wr_data = slave_address (write on cfg_wr_en)
//
//  One input transaction per cycle while no frame end waits; the frame state is
//  updated from the input register, by a single unrolled CRC byte step.
//  A good frame end loads a seven-byte reply, sent one byte per cycle unless stalled.
//  Any frame end, good or not, waits in the input register until the previous
//  reply is gone or its last byte leaves in that cycle; transactions behind it wait too.
//  Reset clears all control and frame state; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "modbus_rtu_level_responder_defines.svh"

module modbus_rtu_level_responder #(
    parameter int unsigned MAX_FRAME = mrtu_pkg::MAX_FRAME_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [7:0] rx_byte, [23:8] level
    input  logic        s_axis_tuser,   // [0] cmd
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] tx_byte
    output logic        m_axis_tlast,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data
);

    logic [7:0]            slave_addr_reg;
    logic                  load_ok;
    mrtu_pkg::reply_load_t load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            slave_addr_reg <= mrtu_pkg::SLAVE_ADDR_RESET;
        else if (cfg_wr_en)
            slave_addr_reg <= cfg_wr_data;
    end

    mrtu_frame_check #(
        .MAX_FRAME (MAX_FRAME)
    ) u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .in_cmd        (s_axis_tuser),
        .in_byte       (s_axis_tdata[7:0]),
        .in_end        (s_axis_tlast),
        .in_level      (s_axis_tdata[23:8]),
        .slave_address (slave_addr_reg),
        .load_ok       (load_ok),
        .load          (load)
    );

    mrtu_reply_tx u_tx (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .load_ok   (load_ok),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_byte  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

    `MRTU_ASSERT_IMPLY(a_load_into_free, clk, rst_n, load.valid, load_ok)
    `MRTU_ASSERT_NEXT(a_reply_starts, clk, rst_n, load.valid, m_axis_tvalid && !m_axis_tlast)
    `MRTU_ASSERT_IMPLY(a_idle_accepts, clk, rst_n, !m_axis_tvalid, load_ok)

endmodule

// ===== tb/modbus_rtu_level_responder_test.sv =====
// ----------------------------------------------------------------------------
// Modbus RTU level responder testbench
// Drives received frame bytes and level samples into the responder and checks
// every reply byte against a cycle-free model of the read responder. A short
// table of hand-written frames comes first, then random well-formed and broken
// frames at several station addresses, most with random idling on both sides.
// ----------------------------------------------------------------------------
module modbus_rtu_level_responder_test;

    localparam int          MAX_FRAME_LEN = mrtu_pkg::MAX_FRAME_DEFAULT;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          DRAIN_CYCLES  = 20;
    localparam int          HOLD_CYCLES   = 300;
    localparam int unsigned CYCLE_LIMIT   = 400000;

    typedef enum logic [2:0] {
        RK_LEVEL,
        RK_DATA,
        RK_CRC_LO,
        RK_CRC_HI,
        RK_CRC_BAD
    } row_kind_t;

    // quiet = 1: no reply is expected from this row, typed in by hand
    typedef struct packed {
        row_kind_t   kind;
        logic [15:0] val;
        logic        last;
        logic        quiet;
    } stim_row_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_last;
    } reply_byte_t;

    localparam int N_ROWS = 27;
    localparam stim_row_t DIRECTED_ROWS [N_ROWS] = '{
        // even frame at the reset address, reply carries the reset level
        '{RK_DATA,    16'h0001, 1'b0, 1'b0},
        '{RK_DATA,    16'h0003, 1'b0, 1'b0},
        '{RK_DATA,    16'h0000, 1'b0, 1'b0},
        '{RK_DATA,    16'h0000, 1'b0, 1'b0},
        '{RK_CRC_LO,  16'h0000, 1'b0, 1'b0},
        '{RK_CRC_HI,  16'h0000, 1'b1, 1'b0},
        // level sample with its end mark set: the mark is ignored
        '{RK_LEVEL,   16'h8000, 1'b1, 1'b1},
        // shortest accepted frame
        '{RK_DATA,    16'h0001, 1'b0, 1'b0},
        '{RK_DATA,    16'h0003, 1'b0, 1'b0},
        '{RK_CRC_LO,  16'h0000, 1'b0, 1'b0},
        '{RK_CRC_HI,  16'h0000, 1'b1, 1'b0},
        // odd frame, full-scale level arrives mid-frame, sum wraps
        '{RK_DATA,    16'h0001, 1'b0, 1'b0},
        '{RK_DATA,    16'h0003, 1'b0, 1'b0},
        '{RK_DATA,    16'h00FF, 1'b0, 1'b0},
        '{RK_DATA,    16'h0012, 1'b0, 1'b0},
        '{RK_LEVEL,   16'hFFFF, 1'b0, 1'b0},
        '{RK_DATA,    16'h0034, 1'b0, 1'b0},
        '{RK_CRC_LO,  16'h0000, 1'b0, 1'b0},
        '{RK_CRC_HI,  16'h0000, 1'b1, 1'b0},
        // three-byte frame is too short
        '{RK_DATA,    16'h00FF, 1'b0, 1'b0},
        '{RK_DATA,    16'h0000, 1'b0, 1'b0},
        '{RK_DATA,    16'h00F0, 1'b1, 1'b1},
        // corrupted CRC
        '{RK_DATA,    16'h0001, 1'b0, 1'b0},
        '{RK_DATA,    16'h0003, 1'b0, 1'b0},
        '{RK_CRC_BAD, 16'h0000, 1'b0, 1'b0},
        '{RK_CRC_HI,  16'h0000, 1'b1, 1'b1},
        // lone byte with end mark
        '{RK_DATA,    16'h0000, 1'b1, 1'b1}
    };

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // [7:0] rx_byte, [23:8] level
    logic        s_axis_tuser;   // [0] cmd
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // [7:0] tx_byte
    logic        m_axis_tlast;
    logic        cfg_wr_en;
    logic [7:0]  cfg_wr_data;

    modbus_rtu_level_responder #(
        .MAX_FRAME(MAX_FRAME_LEN)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    // responder model state
    logic [7:0]  m_slave;
    logic [15:0] m_level;
    logic [15:0] m_crc;
    logic [8:0]  m_count;
    logic [7:0]  m_tail [2];
    logic [7:0]  m_addr_byte;
    logic [7:0]  m_func_byte;
    logic [7:0]  m_payload [2];

    reply_byte_t pending_reply [$];
    reply_byte_t head;

    int unsigned items_sent;
    int unsigned frames_sent;
    int unsigned replies_checked;
    int unsigned fail_count;
    int unsigned cycle_count;
    bit          sender_idle;
    bit          receiver_idle;
    bit          hold_req;
    bit          hold_done;

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    function automatic logic [15:0] crc16_modbus_step(input logic [15:0] acc,
                                                      input logic [7:0] data);
        logic [15:0] r;
        r = acc ^ {8'h00, data};
        for (int i = 0; i < 8; i++)
        begin
            r = r[0] ? ((r >> 1) ^ mrtu_pkg::CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    task automatic clear_frame_state();
        m_crc        = mrtu_pkg::CRC_INIT;
        m_count      = '0;
        m_tail[0]    = '0;
        m_tail[1]    = '0;
        m_addr_byte  = '0;
        m_func_byte  = '0;
        m_payload[0] = '0;
        m_payload[1] = '0;
    endtask

    // Advance the model by one accepted transaction; queue the reply bytes it
    // produces unless the caller has typed the outcome in by hand.
    task automatic predict_reply(input logic cmd, input logic [7:0] rx,
                                 input logic frame_end, input logic [15:0] lvl,
                                 input bit use_model);
        logic [8:0]  n;
        int unsigned len;
        logic [15:0] value;
        logic [15:0] rcrc;
        logic [7:0]  rb [7];
        if (cmd)
        begin
            m_level = lvl;
            return;
        end
        n = m_count;
        if (n >= 2)
            m_crc = crc16_modbus_step(m_crc, m_tail[0]);
        m_tail[0] = m_tail[1];
        m_tail[1] = rx;
        if (n == 0) m_addr_byte = rx;
        if (n == 1) m_func_byte = rx;
        if (n == 3) m_payload[0] = rx;
        if (n == 4) m_payload[1] = rx;
        if (m_count < mrtu_pkg::COUNT_SAT)
            m_count = m_count + 9'd1;
        if (!frame_end)
            return;
        len = int'(n) + 1;
        if (use_model && len >= 4 && len <= MAX_FRAME_LEN &&
            m_tail[0] == m_crc[7:0] && m_tail[1] == m_crc[15:8] &&
            m_addr_byte == m_slave && m_func_byte == mrtu_pkg::FUNC_READ)
        begin
            value = len[0] ? ({m_payload[0], m_payload[1]} + m_level) : m_level;
            rb[0] = m_slave;
            rb[1] = mrtu_pkg::FUNC_READ;
            rb[2] = mrtu_pkg::BYTE_COUNT_FIELD;
            rb[3] = value[15:8];
            rb[4] = value[7:0];
            rcrc = mrtu_pkg::CRC_INIT;
            for (int k = 0; k < 5; k++)
                rcrc = crc16_modbus_step(rcrc, rb[k]);
            rb[5] = rcrc[7:0];
            rb[6] = rcrc[15:8];
            for (int k = 0; k < 7; k++)
                pending_reply.push_back('{tx_byte: rb[k], tx_last: (k == 6)});
        end
        clear_frame_state();
    endtask

    task automatic put_item(input logic cmd, input logic [7:0] rx, input logic frame_end,
                            input logic [15:0] lvl, input bit use_model);
        int unsigned gap;
        if (sender_idle && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 18);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {lvl, rx};
        s_axis_tuser  <= cmd;
        s_axis_tlast  <= frame_end;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
        predict_reply(cmd, rx, frame_end, lvl, use_model);
    endtask

    task automatic put_level_sample();
        put_item(1'b1, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                 16'($urandom), 1'b1);
    endtask

    // Send a len-byte frame; when len > 1 the last two carry the CRC of the rest.
    task automatic send_frame(input int len, input bit addr_ok, input bit func_ok,
                              input bit crc_ok);
        logic [7:0]  fb [$];
        logic [15:0] c;
        if (len < 2)
        begin
            put_item(1'b0, 8'($urandom_range(0, 255)), 1'b1, 16'($urandom), 1'b1);
            frames_sent++;
            return;
        end
        for (int i = 0; i < len - 2; i++)
            fb.push_back(8'($urandom_range(0, 255)));
        if (len > 2)
            fb[0] = addr_ok ? m_slave : m_slave ^ 8'($urandom_range(1, 255));
        if (len > 3)
            fb[1] = func_ok ? mrtu_pkg::FUNC_READ
                            : mrtu_pkg::FUNC_READ ^ 8'($urandom_range(1, 255));
        c = mrtu_pkg::CRC_INIT;
        foreach (fb[k])
            c = crc16_modbus_step(c, fb[k]);
        if (!crc_ok)
            c = c ^ (16'd1 << $urandom_range(0, 15));
        fb.push_back(c[7:0]);
        fb.push_back(c[15:8]);
        foreach (fb[k])
        begin
            if (k > 0 && $urandom_range(0, 15) == 0)
                put_level_sample();
            put_item(1'b0, fb[k], k == fb.size() - 1, 16'($urandom), 1'b1);
        end
        frames_sent++;
    endtask

    task automatic run_random(input int unsigned count);
        int unsigned start;
        int unsigned pick;
        start = items_sent;
        while (items_sent - start < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
                put_level_sample();
            else if (pick < 68)
                send_frame(($urandom_range(0, 19) == 0) ? $urandom_range(13, 40)
                                                        : $urandom_range(4, 12), 1, 1, 1);
            else if (pick < 74)
                send_frame($urandom_range(4, 10), 0, 1, 1);
            else if (pick < 80)
                send_frame($urandom_range(4, 10), 1, 0, 1);
            else if (pick < 88)
                send_frame($urandom_range(4, 10), 1, 1, 0);
            else if (pick < 94)
                send_frame($urandom_range(1, 3), 1, 1, 1);
            else
                send_frame($urandom_range(4, 10), 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
    endtask

    // Change the station address only once the responder has gone quiet.
    task automatic write_station(input logic [7:0] addr);
        s_axis_tvalid <= 1'b0;
        while (pending_reply.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= addr;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        m_slave = addr;
    endtask

    // reply sink: random stalls plus one long hold-off on request
    initial
    begin
        int unsigned stall;
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (receiver_idle && $urandom_range(0, 7) == 0)
            begin
                stall = $urandom_range(1, 18);
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_reply.size() == 0)
            begin
                $error("tx_byte: no reply expected, got %02h (tx_last %0b)",
                       m_axis_tdata, m_axis_tlast);
                fail_count++;
            end
            else
            begin
                head = pending_reply.pop_front();
                replies_checked++;
                if (m_axis_tdata !== head.tx_byte)
                begin
                    $error("tx_byte mismatch: expected %02h, got %02h",
                           head.tx_byte, m_axis_tdata);
                    fail_count++;
                end
                if (m_axis_tlast !== head.tx_last)
                begin
                    $error("tx_last mismatch: expected %0b, got %0b",
                           head.tx_last, m_axis_tlast);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        stim_row_t   row;
        logic [15:0] row_crc;
        logic [7:0]  rx;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        s_axis_tlast  = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        sender_idle   = 1'b1;
        receiver_idle = 1'b1;
        hold_req      = 1'b0;
        hold_done     = 1'b0;
        m_slave       = mrtu_pkg::SLAVE_ADDR_RESET;
        m_level       = '0;
        clear_frame_state();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed frames at the reset station address
        row_crc = mrtu_pkg::CRC_INIT;
        for (int i = 0; i < N_ROWS; i++)
        begin
            row = DIRECTED_ROWS[i];
            case (row.kind)
                RK_LEVEL:   rx = 8'($urandom_range(0, 255));
                RK_DATA:    rx = row.val[7:0];
                RK_CRC_LO:  rx = row_crc[7:0];
                RK_CRC_HI:  rx = row_crc[15:8];
                RK_CRC_BAD: rx = row_crc[7:0] ^ 8'h01;
                default:    rx = 8'h00;
            endcase
            if (row.kind == RK_LEVEL)
                put_item(1'b1, rx, row.last, row.val, !row.quiet);
            else
                put_item(1'b0, rx, row.last, 16'($urandom), !row.quiet);
            if (row.kind == RK_DATA)
                row_crc = crc16_modbus_step(row_crc, rx);
            if (row.kind != RK_LEVEL && row.last)
            begin
                row_crc = mrtu_pkg::CRC_INIT;
                frames_sent++;
            end
        end

        write_station(8'h00);
        run_random(30);

        write_station(8'hFF);
        // one byte past the longest accepted frame
        send_frame(MAX_FRAME_LEN + 1, 1, 1, 1);
        hold_req = 1'b1;
        run_random(50);

        write_station(8'($urandom_range(2, 254)));
        run_random(25);
        sender_idle   = 1'b0;
        receiver_idle = 1'b0;
        run_random(25);

        s_axis_tvalid <= 1'b0;
        while (pending_reply.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d input transactions in %0d frames, %0d reply bytes checked",
                 items_sent, frames_sent, replies_checked);
        $display("Station addresses 01, 00, FF and %02h; frames from 1 to %0d bytes",
                 m_slave, MAX_FRAME_LEN + 1);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
